FILE: hdl/assert_macros.svh
// Assertion macros shared by the primitive assembler RTL.
// Each macro expects clk_i and rst_ni in scope; checks are off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define PA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define PA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pa_pkg.sv
// Package for the primitive assembler: topology, format and primitive codes,
// the configuration and queue word types, and the index format mask.
// No dependencies.
package pa_pkg;

  localparam int unsigned CORNER_W  = 32;
  localparam int unsigned TOPO_W    = 3;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Register select is bit 2 of paddr (registers at byte 0 and byte 4).
  localparam logic REG_TOPOLOGY     = 1'b0;
  localparam logic REG_INDEX_FORMAT = 1'b1;

  typedef enum logic [2:0] {
    TOPO_POINTS     = 3'd0,
    TOPO_LINES      = 3'd1,
    TOPO_LINE_LOOP  = 3'd2,
    TOPO_LINE_STRIP = 3'd3,
    TOPO_TRIANGLES  = 3'd4,
    TOPO_TRI_STRIP  = 3'd5,
    TOPO_TRI_FAN    = 3'd6
  } topo_e;

  typedef enum logic [1:0] {
    FMT_BYTE = 2'd0,
    FMT_HALF = 2'd1,
    FMT_WORD = 2'd2,
    FMT_NONE = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_TRI   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [TOPO_W-1:0] topology;
    fmt_e              index_format;
  } cfg_t;

  // One queue word: a primitive, optionally followed by the loop-closing line
  // from corner b back to the first index of the draw.
  typedef struct packed {
    kind_e               kind;
    logic [CORNER_W-1:0] a;
    logic [CORNER_W-1:0] b;
    logic [CORNER_W-1:0] c;
    logic                close_line;
    logic [CORNER_W-1:0] close_b;
  } job_t;

  function automatic logic [CORNER_W-1:0] fmt_mask(fmt_e f);
    logic [CORNER_W-1:0] m;
    unique case (f)
      FMT_BYTE: m = CORNER_W'(32'h0000_00FF);
      FMT_HALF: m = CORNER_W'(32'h0000_FFFF);
      FMT_WORD: m = '1;
      FMT_NONE: m = '0;
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/pa_front.sv
// Front end of the primitive assembler: accepts index words, masks them and
// tracks the draw state, and pushes finished primitives into the queue.
// Depends on pa_pkg.
module pa_front #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pa_pkg::cfg_t                 cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pa_pkg::CORNER_W-1:0]  vertex_index_i,
  input  logic                         last_vertex_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output pa_pkg::job_t                 job_o
);

  localparam int unsigned CW = pa_pkg::CORNER_W;

  logic [INDEX_BITS-1:0] first_q, first_d, prev_q, prev_d, older_q, older_d;
  logic [1:0]            seen_q, seen_d, phase_q, phase_d;
  logic                  parity_q, parity_d;

  logic [CW-1:0]         fmt_m;
  logic [INDEX_BITS-1:0] v, first_eff;
  logic [CW-1:0]         v_w, prev_w, older_w, first_w;
  logic                  accept, produce;
  pa_pkg::topo_e         topo;

  assign fmt_m     = pa_pkg::fmt_mask(cfg_i.index_format);
  assign v         = vertex_index_i[INDEX_BITS-1:0] & fmt_m[INDEX_BITS-1:0];
  assign first_eff = (seen_q == 2'd0) ? v : first_q;
  assign v_w       = CW'(v);
  assign prev_w    = CW'(prev_q);
  assign older_w   = CW'(older_q);
  assign first_w   = CW'(first_eff);
  assign topo      = pa_pkg::topo_e'(cfg_i.topology);

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && produce;

  always_comb begin
    job_o            = '0;
    job_o.kind       = pa_pkg::KIND_POINT;
    produce          = 1'b0;
    phase_d          = phase_q;
    parity_d         = parity_q;
    unique case (topo)
      pa_pkg::TOPO_POINTS: begin
        produce = 1'b1;
        job_o.a = v_w;
      end
      pa_pkg::TOPO_LINES: begin
        if (phase_q == 2'd0) begin
          phase_d = 2'd1;
        end else begin
          produce    = 1'b1;
          job_o.kind = pa_pkg::KIND_LINE;
          job_o.a    = prev_w;
          job_o.b    = v_w;
          phase_d    = 2'd0;
        end
      end
      pa_pkg::TOPO_LINE_LOOP, pa_pkg::TOPO_LINE_STRIP: begin
        if (seen_q != 2'd0) begin
          produce    = 1'b1;
          job_o.kind = pa_pkg::KIND_LINE;
          job_o.a    = prev_w;
          job_o.b    = v_w;
          // The loop closes back to the first index on the last word of a draw.
          job_o.close_line = (topo == pa_pkg::TOPO_LINE_LOOP) && last_vertex_i;
          job_o.close_b    = first_w;
        end
      end
      pa_pkg::TOPO_TRIANGLES: begin
        if (phase_q >= 2'd2) begin
          produce    = 1'b1;
          job_o.kind = pa_pkg::KIND_TRI;
          job_o.a    = older_w;
          job_o.b    = prev_w;
          job_o.c    = v_w;
          phase_d    = 2'd0;
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end
      pa_pkg::TOPO_TRI_STRIP: begin
        if (seen_q >= 2'd2) begin
          produce    = 1'b1;
          job_o.kind = pa_pkg::KIND_TRI;
          // Odd strip triangles swap their first two corners to keep winding.
          job_o.a    = parity_q ? prev_w : older_w;
          job_o.b    = parity_q ? older_w : prev_w;
          job_o.c    = v_w;
          parity_d   = !parity_q;
        end
      end
      pa_pkg::TOPO_TRI_FAN: begin
        if (seen_q >= 2'd2) begin
          produce    = 1'b1;
          job_o.kind = pa_pkg::KIND_TRI;
          job_o.a    = first_w;
          job_o.b    = prev_w;
          job_o.c    = v_w;
        end
      end
      default: begin
      end
    endcase

    if (last_vertex_i) begin
      first_d  = '0;
      prev_d   = '0;
      older_d  = '0;
      seen_d   = 2'd0;
      phase_d  = 2'd0;
      parity_d = 1'b0;
    end else begin
      first_d = first_eff;
      prev_d  = v;
      older_d = prev_q;
      seen_d  = (seen_q < 2'd2) ? seen_q + 2'd1 : seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      prev_q   <= '0;
      older_q  <= '0;
      seen_q   <= 2'd0;
      phase_q  <= 2'd0;
      parity_q <= 1'b0;
    end else if (accept) begin
      first_q  <= first_d;
      prev_q   <= prev_d;
      older_q  <= older_d;
      seen_q   <= seen_d;
      phase_q  <= phase_d;
      parity_q <= parity_d;
    end
  end

endmodule

FILE: hdl/pa_fifo.sv
// Short queue of primitive words between the assembler front and back ends.
// Depends on pa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pa_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  pa_pkg::job_t data_i,
  input  logic         pop_i,
  output pa_pkg::job_t data_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pa_pkg::job_t     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `PA_ASSERT_IMP(a_no_push_full, full_o, !push_i, "queue pushed while full")
  `PA_ASSERT_IMP(a_no_pop_empty, empty_o, !pop_i, "queue popped while empty")
  `PA_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "queue count out of range")

endmodule

FILE: hdl/pa_back.sv
// Back end of the primitive assembler: takes queue words and drives the
// registered result channel, splitting a loop close into two words.
// Depends on pa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pa_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pa_pkg::job_t                job_i,
  input  logic                        q_empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pa_pkg::CORNER_W-1:0] corner_a_o,
  output logic [pa_pkg::CORNER_W-1:0] corner_b_o,
  output logic [pa_pkg::CORNER_W-1:0] corner_c_o,
  output logic [1:0]                  prim_kind_o,
  output logic                        last_of_run_o
);

  localparam int unsigned CW = pa_pkg::CORNER_W;

  logic          out_valid_q, out_valid_d, second_q, second_d;
  logic          load;
  logic [CW-1:0] a_q, a_d, b_q, b_d, c_q, c_d, close_a_q, close_a_d, close_b_q, close_b_d;
  pa_pkg::kind_e kind_q, kind_d;
  logic          last_q, last_d;

  // The output register may take a new word when empty or when drained now.
  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = load && !second_q && !q_empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    second_d    = second_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    kind_d      = kind_q;
    last_d      = last_q;
    close_a_d   = close_a_q;
    close_b_d   = close_b_q;
    if (load) begin
      if (second_q) begin
        out_valid_d = 1'b1;
        second_d    = 1'b0;
        a_d         = close_a_q;
        b_d         = close_b_q;
        c_d         = '0;
        kind_d      = pa_pkg::KIND_LINE;
        last_d      = 1'b1;
      end else if (!q_empty_i) begin
        out_valid_d = 1'b1;
        second_d    = job_i.close_line;
        a_d         = job_i.a;
        b_d         = job_i.b;
        c_d         = job_i.c;
        kind_d      = job_i.kind;
        last_d      = !job_i.close_line;
        close_a_d   = job_i.b;
        close_b_d   = job_i.close_b;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    c_q       <= c_d;
    kind_q    <= kind_d;
    last_q    <= last_d;
    close_a_q <= close_a_d;
    close_b_q <= close_b_d;
  end

  assign out_valid_o   = out_valid_q;
  assign corner_a_o    = a_q;
  assign corner_b_o    = b_q;
  assign corner_c_o    = c_q;
  assign prim_kind_o   = kind_q;
  assign last_of_run_o = last_q;

  `PA_ASSERT_IMP(a_second_needs_first, second_q, out_valid_q,
                 "closing line pending without the strip line on the output")
  `PA_ASSERT_IMP(a_not_last_means_pending, out_valid_q && !last_q, second_q,
                 "result not marked last but no second word pending")
  `PA_ASSERT_IMP(a_point_corners_zero, out_valid_q && (kind_q == pa_pkg::KIND_POINT),
                 (b_q == '0) && (c_q == '0), "point carries nonzero corners")

endmodule

FILE: hdl/primitive_assembler.sv
// Primitive assembler top level: configuration registers, front end, queue
// and back end. Depends on pa_pkg, pa_front, pa_fifo and pa_back.
//
// Usage: index words enter on the in_valid_i/in_ready_o channel, one vertex
// index per word, with last_vertex_i set on the final index of a draw.
// Primitives leave on the out_valid_o/out_ready_i channel as words carrying
// three corners, the primitive kind and last_of_run_o, which marks the final
// word caused by one input. Topology and index format are set through the APB
// port (topology at byte 0, index format at byte 4) by the user only while the
// block is idle, which the block does not enforce. An accepted index passes the
// queue, then the output register. Throughput is one index per cycle while the
// queue is not full; a line loop close emits two words for its last index,
// absorbed by the queue of QUEUE_DEPTH words between front and back end.
// Reset clears the draw state, the queue and the output register, and sets
// points topology with word indices. When the receiver stalls the output word
// holds, the queue fills, and in_ready_o drops once the queue is full.
module primitive_assembler #(
  parameter int unsigned INDEX_BITS  = 32,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pa_pkg::PADDR_W-1:0]  paddr,
  input  logic [pa_pkg::PDATA_W-1:0]  pwdata,
  output logic [pa_pkg::PDATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pa_pkg::CORNER_W-1:0] vertex_index_i,
  input  logic                        last_vertex_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pa_pkg::CORNER_W-1:0] corner_a_o,
  output logic [pa_pkg::CORNER_W-1:0] corner_b_o,
  output logic [pa_pkg::CORNER_W-1:0] corner_c_o,
  output logic [1:0]                  prim_kind_o,
  output logic                        last_of_run_o
);

  localparam int unsigned DW = pa_pkg::PDATA_W;

  logic [pa_pkg::TOPO_W-1:0] topology_q;
  pa_pkg::fmt_e              format_q;
  pa_pkg::cfg_t              cfg;
  logic                      wr_en;
  logic                      push, pop, q_full, q_empty;
  pa_pkg::job_t              push_job, head_job;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topology_q <= pa_pkg::TOPO_POINTS;
      format_q   <= pa_pkg::FMT_WORD;
    end else if (wr_en) begin
      unique case (paddr[2])
        pa_pkg::REG_TOPOLOGY:     topology_q <= pwdata[pa_pkg::TOPO_W-1:0];
        pa_pkg::REG_INDEX_FORMAT: format_q   <= pa_pkg::fmt_e'(pwdata[1:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pa_pkg::REG_TOPOLOGY:     prdata = DW'(topology_q);
      pa_pkg::REG_INDEX_FORMAT: prdata = DW'(format_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.topology     = topology_q;
  assign cfg.index_format = format_q;

  pa_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .vertex_index_i(vertex_index_i),
    .last_vertex_i (last_vertex_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  pa_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .pop_i  (pop),
    .data_o (head_job),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  pa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .corner_a_o   (corner_a_o),
    .corner_b_o   (corner_b_o),
    .corner_c_o   (corner_c_o),
    .prim_kind_o  (prim_kind_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

FILE: test/primitive_assembler_tb.sv
// Self-checking testbench for primitive_assembler: a directed table, then random draws over
// every topology and index format, with random stalls on both channels.
// Depends on pa_pkg and the primitive_assembler RTL.
module primitive_assembler_tb;
  import pa_pkg::*;

  localparam logic [2:0] TOPO_UNUSED = 3'd7;
  localparam logic [PADDR_W-1:0] ADDR_TOPOLOGY = {REG_TOPOLOGY, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_FORMAT = {REG_INDEX_FORMAT, 2'b00};
  localparam int RANDOM_WORDS = 1800;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_LIMIT = 60;
  localparam int NUM_ROWS = 36;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    kind_e       kind;
    logic        last_of_run;
  } prim_word_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_TOPO, ROW_FMT} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_e;

  typedef struct packed {
    row_kind_e   what;
    logic [31:0] value;
    logic        closes;
    row_check_e  chk;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    kind_e       kind;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] vertex_index_i = '0;
  logic        last_vertex_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [31:0] corner_a_o;
  logic [31:0] corner_b_o;
  logic [31:0] corner_c_o;
  logic [1:0]  prim_kind_o;
  logic        last_of_run_o;

  primitive_assembler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .vertex_index_i (vertex_index_i),
    .last_vertex_i  (last_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .corner_a_o     (corner_a_o),
    .corner_b_o     (corner_b_o),
    .corner_c_o     (corner_c_o),
    .prim_kind_o    (prim_kind_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the registers and the draw state.
  logic [2:0]  topo_cfg = TOPO_POINTS;
  fmt_e        fmt_cfg = FMT_WORD;
  logic [31:0] hub_index = '0;
  logic [31:0] prev_index = '0;
  logic [31:0] older_index = '0;
  int          seen_cnt = 0;
  int          phase_cnt = 0;
  bit          odd_strip = 1'b0;

  prim_word_t  expected_prims[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          pending_gap = 0;
  int          ready_wait = 0;
  bit          feeding = 1'b0;
  bit          calm = 1'b0;

  row_t directed_rows [NUM_ROWS] = '{
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b0, CHK_ONE, 32'hFFFF_FFFF, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'h0, 1'b1, CHK_ONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_FMT, 32'(FMT_BYTE), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'h1234_5678, 1'b1, CHK_ONE, 32'h78, 32'h0, 32'h0, KIND_POINT},
    '{ROW_FMT, 32'(FMT_HALF), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'hABCD_EF01, 1'b1, CHK_ONE, 32'hEF01, 32'h0, 32'h0, KIND_POINT},
    '{ROW_FMT, 32'(FMT_NONE), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b1, CHK_ONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_FMT, 32'(FMT_WORD), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_TOPO, 32'(TOPO_LINES), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd5, 1'b0, CHK_NONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd6, 1'b1, CHK_ONE, 32'd5, 32'd6, 32'h0, KIND_LINE},
    '{ROW_TOPO, 32'(TOPO_LINE_LOOP), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd9, 1'b1, CHK_NONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd1, 1'b0, CHK_NONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd2, 1'b0, CHK_ONE, 32'd1, 32'd2, 32'h0, KIND_LINE},
    '{ROW_WORD, 32'd3, 1'b1, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_TOPO, 32'(TOPO_LINE_STRIP), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd10, 1'b0, CHK_NONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd11, 1'b1, CHK_ONE, 32'd10, 32'd11, 32'h0, KIND_LINE},
    '{ROW_TOPO, 32'(TOPO_TRIANGLES), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd1, 1'b0, CHK_NONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd2, 1'b0, CHK_NONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd3, 1'b0, CHK_ONE, 32'd1, 32'd2, 32'd3, KIND_TRI},
    '{ROW_WORD, 32'd4, 1'b1, CHK_NONE, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_TOPO, 32'(TOPO_TRI_STRIP), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd1, 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd2, 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd3, 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd4, 1'b1, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_TOPO, 32'(TOPO_TRI_FAN), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd1, 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd2, 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd3, 1'b1, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_TOPO, 32'(TOPO_UNUSED), 1'b0, CHK_MODEL, 32'h0, 32'h0, 32'h0, KIND_POINT},
    '{ROW_WORD, 32'd1, 1'b1, CHK_NONE, 32'h0, 32'h0, 32'h0, KIND_POINT}
  };

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch in %s: got %h, want %h", what, got, want);
  endtask

  function automatic int pick_gap();
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic logic [31:0] pick_index();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 15));
      3: return $urandom & 32'h0000_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] format_mask(fmt_e f);
    case (f)
      FMT_BYTE: return 32'h0000_00FF;
      FMT_HALF: return 32'h0000_FFFF;
      FMT_WORD: return 32'hFFFF_FFFF;
      default:  return 32'h0;
    endcase
  endfunction

  function automatic prim_word_t make_prim(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input kind_e kind,
                                           input logic closes);
    prim_word_t w;
    w.a = a;
    w.b = b;
    w.c = c;
    w.kind = kind;
    w.last_of_run = closes;
    return w;
  endfunction

  // Works out the primitives that one accepted index word causes and queues them.
  task automatic assemble(input logic [31:0] raw, input logic closes, output int made);
    logic [31:0] v;
    prim_word_t  got [2];
    v = raw & format_mask(fmt_cfg);
    made = 0;
    if (seen_cnt == 0) hub_index = v;
    case (topo_cfg)
      TOPO_POINTS: begin
        got[made] = make_prim(v, '0, '0, KIND_POINT, 1'b0);
        made++;
      end
      TOPO_LINES: begin
        if (phase_cnt == 0) begin
          phase_cnt = 1;
        end else begin
          got[made] = make_prim(prev_index, v, '0, KIND_LINE, 1'b0);
          made++;
          phase_cnt = 0;
        end
      end
      TOPO_LINE_LOOP, TOPO_LINE_STRIP: begin
        if (seen_cnt >= 1) begin
          got[made] = make_prim(prev_index, v, '0, KIND_LINE, 1'b0);
          made++;
          // The loop closes back to the first index on the last word of the draw.
          if (topo_cfg == TOPO_LINE_LOOP && closes) begin
            got[made] = make_prim(v, hub_index, '0, KIND_LINE, 1'b0);
            made++;
          end
        end
      end
      TOPO_TRIANGLES: begin
        if (phase_cnt >= 2) begin
          got[made] = make_prim(older_index, prev_index, v, KIND_TRI, 1'b0);
          made++;
          phase_cnt = 0;
        end else begin
          phase_cnt++;
        end
      end
      TOPO_TRI_STRIP: begin
        if (seen_cnt >= 2) begin
          if (!odd_strip) got[made] = make_prim(older_index, prev_index, v, KIND_TRI, 1'b0);
          else got[made] = make_prim(prev_index, older_index, v, KIND_TRI, 1'b0);
          made++;
          odd_strip = !odd_strip;
        end
      end
      TOPO_TRI_FAN: begin
        if (seen_cnt >= 2) begin
          got[made] = make_prim(hub_index, prev_index, v, KIND_TRI, 1'b0);
          made++;
        end
      end
      default: begin
      end
    endcase
    older_index = prev_index;
    prev_index = v;
    if (seen_cnt < 2) seen_cnt++;
    if (made > 0) got[made-1].last_of_run = 1'b1;
    for (int i = 0; i < made; i++) expected_prims.push_back(got[i]);
    if (closes) begin
      hub_index = '0;
      prev_index = '0;
      older_index = '0;
      seen_cnt = 0;
      phase_cnt = 0;
      odd_strip = 1'b0;
    end
  endtask

  // Sends one index word. Valid stays up when the next word follows with no gap.
  task automatic drive_word(input logic [31:0] raw, input logic closes, output int made);
    if (pending_gap > 0) repeat (pending_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    vertex_index_i <= raw;
    last_vertex_i <= closes;
    do @(posedge clk_i); while (!in_ready_o);
    assemble(raw, closes, made);
    words_sent++;
    pending_gap = pick_gap();
    if (pending_gap > 0) in_valid_i <= 1'b0;
    feeding = (pending_gap == 0);
  endtask

  task automatic stop_feeding();
    if (feeding) in_valid_i <= 1'b0;
    feeding = 1'b0;
  endtask

  // Always lets at least one edge pass so valid is never driven twice in one step.
  task automatic wait_drained();
    stop_feeding();
    do @(posedge clk_i); while (expected_prims.size() != 0);
  endtask

  // Writes a register once the block is idle, then reads it back.
  task automatic configure(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_TOPOLOGY) topo_cfg = value[2:0];
    else fmt_cfg = fmt_e'(value[1:0]);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) report_mismatch("register readback", prdata, value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_primitive();
    prim_word_t want;
    if (expected_prims.size() == 0) begin
      report_mismatch("word with nothing pending, corner_a", corner_a_o, 32'h0);
    end else begin
      want = expected_prims.pop_front();
      if (corner_a_o !== want.a) report_mismatch("corner_a", corner_a_o, want.a);
      if (corner_b_o !== want.b) report_mismatch("corner_b", corner_b_o, want.b);
      if (corner_c_o !== want.c) report_mismatch("corner_c", corner_c_o, want.c);
      if (prim_kind_o !== want.kind)
        report_mismatch("prim_kind", 32'(prim_kind_o), 32'(want.kind));
      if (last_of_run_o !== want.last_of_run)
        report_mismatch("last_of_run", 32'(last_of_run_o), 32'(want.last_of_run));
    end
  endtask

  // Receiver: checks each accepted word, then stalls for a random number of cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_primitive();
        ready_wait = pick_gap();
        out_ready_i <= (ready_wait == 0);
      end else if (ready_wait > 0) begin
        ready_wait--;
        if (ready_wait == 0) out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("primitive_assembler_tb NOT OK");
      $finish;
    end
  end

  initial begin
    row_t        row;
    int          made;
    int          draws;
    int          span;
    bit          open_end;
    logic [2:0]  new_topo;
    logic [1:0]  new_fmt;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.what)
        ROW_TOPO: configure(ADDR_TOPOLOGY, row.value);
        ROW_FMT: configure(ADDR_FORMAT, row.value);
        default: begin
          drive_word(row.value, row.closes, made);
          // Rows with a typed answer replace what the predictor queued.
          if (row.chk != CHK_MODEL) begin
            repeat (made) void'(expected_prims.pop_back());
            if (row.chk == CHK_ONE)
              expected_prims.push_back(make_prim(row.a, row.b, row.c, row.kind, 1'b1));
          end
        end
      endcase
    end

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      new_topo = ($urandom_range(0, 15) == 0) ? TOPO_UNUSED : 3'($urandom_range(0, 6));
      new_fmt = ($urandom_range(0, 7) == 0) ? FMT_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: configure(ADDR_TOPOLOGY, 32'(new_topo));
        1: configure(ADDR_FORMAT, 32'(new_fmt));
        default: begin
          configure(ADDR_TOPOLOGY, 32'(new_topo));
          configure(ADDR_FORMAT, 32'(new_fmt));
        end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      draws = $urandom_range(1, 6);
      for (int d = 0; d < draws; d++) begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        // Now and then a draw stays open so the next setting picks up its state.
        open_end = (d == draws - 1) && ($urandom_range(0, 3) == 0);
        for (int k = 0; k < span; k++)
          drive_word(pick_index(), (k == span - 1) && !open_end, made);
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_prims.size() == 0) begin
      $display("primitive_assembler_tb OK");
    end else begin
      $display("primitive_assembler_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pa_pkg.sv
hdl/pa_front.sv
hdl/pa_fifo.sv
hdl/pa_back.sv
hdl/primitive_assembler.sv
test/primitive_assembler_tb.sv
